// ----- design/gid_pkg.sv -----
// Shared types and constants for the GPIO interrupt detector.
// No dependencies; imported by the pin cell and the top level.
`timescale 1ns / 1ps

package gid_pkg;

  // Field widths fixed by the register map
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned PIDX_W   = 4;
  localparam int unsigned DATA_W   = 8;
  localparam int unsigned LEVEL_W  = 16;
  localparam int unsigned TARGET_W = 3;

  localparam logic [TARGET_W-1:0] APP_TARGET_RST = 3'd4;

  // Word kinds
  localparam logic [KIND_W-1:0] KIND_WR_CFG = 3'd0;
  localparam logic [KIND_W-1:0] KIND_WR_STS = 3'd1;
  localparam logic [KIND_W-1:0] KIND_RD_CFG = 3'd2;
  localparam logic [KIND_W-1:0] KIND_RD_STS = 3'd3;
  localparam logic [KIND_W-1:0] KIND_TICK   = 3'd4;

  // Config byte layout
  localparam int unsigned CFG_EN     = 0;
  localparam int unsigned CFG_POL    = 1;
  localparam int unsigned CFG_MODE_L = 2;
  localparam int unsigned CFG_MODE_H = 3;
  localparam int unsigned CFG_RAW    = 4;
  localparam int unsigned CFG_TGT_L  = 5;
  localparam int unsigned CFG_TGT_H  = 7;

  // Detect modes
  localparam logic [1:0] MODE_LEVEL   = 2'd0;
  localparam logic [1:0] MODE_RISING  = 2'd1;
  localparam logic [1:0] MODE_FALLING = 2'd2;
  localparam logic [1:0] MODE_BOTH    = 2'd3;

  // Per-pin command derived from the current word
  typedef struct packed {
    logic cfg_we;   // write config byte to this pin
    logic sts_clr;  // clear pending bit of this pin
    logic tick;     // sample tick, all pins
  } gid_cmd_t;

  // Per-pin status back to the top level
  typedef struct packed {
    logic [DATA_W-1:0] cfg;  // current config byte
    logic              pend; // current pending bit
    logic              irq;  // contribution to summary after this update
  } gid_cell_out_t;

endpackage

// ----- design/gpio_interrupt_detector_unit.sv -----
// GPIO interrupt detector top level: input word register, NUM_PINS pin cells, result register.
// A word in the input word register moves on into the result register when that register is free.
// One word per cycle unless stalled; a stall holds the result, and in_ready_o drops while a word waits.
// Reset (async, active low): configs, pending bits and previous levels clear, app_target = 4.
// Depends on gid_pkg and gid_pin_cell.
`timescale 1ns / 1ps

module gpio_interrupt_detector_unit #(
  parameter int unsigned NUM_PINS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // request words
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [gid_pkg::KIND_W-1:0]   kind_i,
  input  logic [gid_pkg::PIDX_W-1:0]   pin_index_i,
  input  logic [gid_pkg::DATA_W-1:0]   write_data_i,
  input  logic [gid_pkg::LEVEL_W-1:0]  pin_levels_i,
  // result words
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [gid_pkg::DATA_W-1:0]   read_data_o,
  output logic                         summary_irq_o,
  // app_target register write
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [gid_pkg::TARGET_W-1:0] cfg_app_target_i
);
  import gid_pkg::*;

  // Input word register
  logic                in_vld_q;
  logic [KIND_W-1:0]   kind_q;
  logic [PIDX_W-1:0]   pidx_q;
  logic [DATA_W-1:0]   wdata_q;
  logic [LEVEL_W-1:0]  levels_q;

  // Result register
  logic                out_vld_q;
  logic [DATA_W-1:0]   rdata_q, rdata_d;
  logic                irq_q, irq_d;

  logic [TARGET_W-1:0] app_target_q;
  logic [LEVEL_W-1:0]  prev_lvl_q;

  logic                out_free, advance;
  logic                do_wcfg, do_wsts, do_rcfg, do_rsts, do_tick;
  logic [NUM_PINS-1:0] sel, irq_vec;
  gid_cell_out_t       cell_st [NUM_PINS];
  logic [DATA_W-1:0]   cfg_rd;
  logic                pend_rd;

  assign out_free   = ~out_vld_q | out_ready_i;
  assign advance    = in_vld_q & out_free;
  assign in_ready_o = ~in_vld_q | out_free;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      kind_q   <= kind_i;
      pidx_q   <= pin_index_i;
      wdata_q  <= write_data_i;
      levels_q <= pin_levels_i;
    end
  end

  // Kind decode; write and tick kinds are gated by a word advancing this cycle
  always_comb begin
    do_wcfg = 1'b0;
    do_wsts = 1'b0;
    do_rcfg = 1'b0;
    do_rsts = 1'b0;
    do_tick = 1'b0;
    unique case (kind_q)
      KIND_WR_CFG: do_wcfg = advance;
      KIND_WR_STS: do_wsts = advance;
      KIND_RD_CFG: do_rcfg = 1'b1;
      KIND_RD_STS: do_rsts = 1'b1;
      KIND_TICK:   do_tick = advance;
      default: ;
    endcase
  end

  // Pin cells
  for (genvar g = 0; g < NUM_PINS; g++) begin : g_pin
    gid_cmd_t cmd;
    logic     lvl_prev, lvl_now;

    assign sel[g] = (32'(pidx_q) == g);

    if (g < LEVEL_W) begin : g_lvl
      assign lvl_prev = prev_lvl_q[g];
      assign lvl_now  = levels_q[g];
    end else begin : g_nolvl
      // no level input: always samples low
      assign lvl_prev = 1'b0;
      assign lvl_now  = 1'b0;
    end

    assign cmd.cfg_we  = do_wcfg & sel[g];
    assign cmd.sts_clr = do_wsts & sel[g] & ~wdata_q[0];
    assign cmd.tick    = do_tick;

    gid_pin_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd),
      .wdata_i     (wdata_q),
      .lvl_prev_i  (lvl_prev),
      .lvl_now_i   (lvl_now),
      .app_target_i(app_target_q),
      .status_o    (cell_st[g])
    );

    assign irq_vec[g] = cell_st[g].irq;
  end

  // Read mux: AND-OR over pins; an address beyond the pins reads zero
  always_comb begin
    cfg_rd  = '0;
    pend_rd = 1'b0;
    for (int i = 0; i < NUM_PINS; i++) begin
      cfg_rd  = cfg_rd | (cell_st[i].cfg & {DATA_W{sel[i]}});
      pend_rd = pend_rd | (cell_st[i].pend & sel[i]);
    end
  end

  always_comb begin
    rdata_d = '0;
    if (do_rcfg) begin
      rdata_d = cfg_rd;
    end else if (do_rsts) begin
      rdata_d = {{(DATA_W-1){1'b0}}, pend_rd};
    end
    irq_d = |irq_vec;
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      rdata_q <= rdata_d;
      irq_q   <= irq_d;
    end
  end

  // Previous levels and app_target
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_lvl_q   <= '0;
      app_target_q <= APP_TARGET_RST;
    end else begin
      if (do_tick) begin
        prev_lvl_q <= levels_q;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        app_target_q <= cfg_app_target_i;
      end
    end
  end

  assign out_valid_o   = out_vld_q;
  assign read_data_o   = rdata_q;
  assign summary_irq_o = irq_q;

endmodule

// ----- design/gid_pin_cell.sv -----
// One pin: config byte, sticky pending bit and edge/level detection.
// Depends on gid_pkg.
`timescale 1ns / 1ps

module gid_pin_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  gid_pkg::gid_cmd_t          cmd_i,
  input  logic [gid_pkg::DATA_W-1:0] wdata_i,
  input  logic                       lvl_prev_i,
  input  logic                       lvl_now_i,
  input  logic [gid_pkg::TARGET_W-1:0] app_target_i,
  output gid_pkg::gid_cell_out_t     status_o
);
  import gid_pkg::*;

  logic [DATA_W-1:0] cfg_q, cfg_d;
  logic              pend_q, pend_d;
  logic              flip, prev_v, now_v, det, armed;

  // Detection through the current polarity bit
  assign flip   = ~cfg_q[CFG_POL];
  assign prev_v = lvl_prev_i ^ flip;
  assign now_v  = lvl_now_i ^ flip;
  assign armed  = cfg_q[CFG_EN] | cfg_q[CFG_RAW];

  always_comb begin
    unique case (cfg_q[CFG_MODE_H:CFG_MODE_L])
      MODE_LEVEL:   det = now_v;
      MODE_RISING:  det = ~prev_v & now_v;
      MODE_FALLING: det = prev_v & ~now_v;
      MODE_BOTH:    det = prev_v ^ now_v;
      default:      det = 1'b0;
    endcase
  end

  // Next state
  always_comb begin
    cfg_d  = cmd_i.cfg_we ? wdata_i : cfg_q;
    pend_d = pend_q;
    if (cmd_i.sts_clr) begin
      pend_d = 1'b0;
    end else if (cmd_i.tick && armed && det) begin
      pend_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q  <= '0;
      pend_q <= 1'b0;
    end else begin
      cfg_q  <= cfg_d;
      pend_q <= pend_d;
    end
  end

  // Summary contribution uses the post-update state
  assign status_o.cfg  = cfg_q;
  assign status_o.pend = pend_q;
  assign status_o.irq  = pend_d & cfg_d[CFG_EN] &
                         (cfg_d[CFG_TGT_H:CFG_TGT_L] == app_target_i);

endmodule

// ----- design/gid_checker.sv -----
// Port-level checks for gpio_interrupt_detector_unit, attached by bind.
// Depends on gid_pkg for field widths.
`timescale 1ns / 1ps

module gid_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [gid_pkg::DATA_W-1:0]   read_data_o,
  input logic                         summary_irq_o
);

  // Stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(read_data_o) &&
    $stable(summary_irq_o))
    else $error("stalled result word changed");

  // Input side stalls only when the result register is full and blocked
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled while output could move");

  // A new result word follows an accepted request word through the input word register
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result word without a matching request word");

endmodule

bind gpio_interrupt_detector_unit gid_checker u_gid_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .read_data_o  (read_data_o),
  .summary_irq_o(summary_irq_o)
);
